### rtl/tfda_pkg.sv
package tfda_pkg;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_FUEL  = 3'd0;
    localparam logic [OP_W-1:0] OP_TICK  = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 3'd2;
    localparam logic [OP_W-1:0] OP_STORE = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_TICKS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_SCALE   = 2'd2;

    localparam logic [31:0] TPS_RESET   = 32'd1000000;
    localparam logic [31:0] STALE_RESET = 32'd200000;
    localparam logic [15:0] SCALE_RESET = 16'd910;

    localparam int GRAMS_W  = 26;
    localparam int RATE_W   = 24;
    localparam int DIST_W   = 34;
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 2 * MUL_W;
    // dividend is grams * ticks_per_second with the /256 folded in
    localparam int DIVD_W   = GRAMS_W + 32 - 8;

    localparam logic [GRAMS_W:0]   FUEL_LIMIT_Q16 = 27'd65536000;
    localparam logic [DIST_W:0]    DIST_ONE_Q24   = 35'd16777216;
    localparam logic [DIST_W:0]    DIST_LIMIT_Q24 = 35'd16777216000;
    localparam logic [RATE_W-1:0]  RATE_MAX       = '1;

endpackage

### rtl/tfda_mul.sv
module tfda_mul
(
    input  logic                         clk,
    input  logic                         enable,
    input  logic [tfda_pkg::MUL_W-1:0]   operand_a,
    input  logic [tfda_pkg::MUL_W-1:0]   operand_b,
    output logic [tfda_pkg::PROD_W-1:0]  product
);

    logic [tfda_pkg::PROD_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            product_reg <= tfda_pkg::PROD_W'(operand_a) * tfda_pkg::PROD_W'(operand_b);
        end
    end

    assign product = product_reg;

endmodule

### rtl/tfda_div.sv
module tfda_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tfda_pkg::DIVD_W-1:0]   dividend,
    input  logic [31:0]                   divisor,
    output logic [tfda_pkg::RATE_W-1:0]   quotient,
    output logic                          done
);

    localparam int QW = tfda_pkg::RATE_W;
    localparam int CW = $clog2(QW);
    localparam logic [1:0] DS_IDLE  = 2'd0;
    localparam logic [1:0] DS_CHECK = 2'd1;
    localparam logic [1:0] DS_STEP  = 2'd2;

    logic [1:0]                     state_reg;
    logic [CW-1:0]                  count_reg;
    logic                           done_reg;
    logic [tfda_pkg::DIVD_W-1:0]    dividend_reg;
    logic [31:0]                    divisor_reg;
    logic [31:0]                    rem_reg;
    logic [QW-1:0]                  shift_reg;

    logic [32:0] trial;
    logic [32:0] trial_diff;
    logic        trial_ge;
    logic        saturate;

    assign trial      = {rem_reg, shift_reg[QW-1]};
    assign trial_diff = trial - {1'b0, divisor_reg};
    assign trial_ge   = trial >= {1'b0, divisor_reg};
    // quotient overflows RATE_W bits iff the upper dividend part reaches the divisor
    assign saturate   = 32'(dividend_reg[tfda_pkg::DIVD_W-1:QW]) >= divisor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DS_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                DS_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= DS_CHECK;
                    end
                end
                DS_CHECK:
                begin
                    count_reg <= '0;
                    if (saturate)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= DS_IDLE;
                    end
                    else
                    begin
                        state_reg <= DS_STEP;
                    end
                end
                DS_STEP:
                begin
                    count_reg <= count_reg + CW'(1);
                    if (count_reg == CW'(QW - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= DS_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= DS_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == DS_IDLE && start)
        begin
            dividend_reg <= dividend;
            divisor_reg  <= divisor;
        end
        if (state_reg == DS_CHECK)
        begin
            if (saturate)
            begin
                shift_reg <= tfda_pkg::RATE_MAX;
            end
            else
            begin
                rem_reg   <= 32'(dividend_reg[tfda_pkg::DIVD_W-1:QW]);
                shift_reg <= dividend_reg[QW-1:0];
            end
        end
        if (state_reg == DS_STEP)
        begin
            rem_reg   <= trial_ge ? trial_diff[31:0] : trial[31:0];
            shift_reg <= {shift_reg[QW-2:0], trial_ge};
        end
    end

    assign quotient = shift_reg;
    assign done     = done_reg;

endmodule

### rtl/trip_fuel_distance_accumulator.sv
// Flow: a fuel pulse that needs a rate division goes from accept through multiply,
// update, the divider (setup, 24 quotient steps, done) and then output load; when
// the quotient saturates the divider skips its steps; every other item goes
// through multiply, update and output load. One item is in work at a time: a new
// item is taken only once the last result is loaded, which waits on out_ready.
// Reset (rst_n low, async): counts, remainders, flags clear, config back to reset.
module trip_fuel_distance_accumulator
#(
    parameter int CALLBACK_PERIOD_MS = 50
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tfda_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [31:0]                          cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [2:0]                           operation,
    input  logic [25:0]                          fuel_grams_q16,
    input  logic [31:0]                          now_ticks,
    input  logic [15:0]                          vehicle_speed_q8,
    input  logic                                 engine_running,
    input  logic                                 write_accepted,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [31:0]                          consumed_grams,
    output logic [31:0]                          distance_meters,
    output logic [31:0]                          ignition_seconds,
    output logic [31:0]                          engine_seconds,
    output logic [23:0]                          fuel_rate_q8,
    output logic                                 dirty_flag,
    output logic                                 write_request,
    output logic                                 fault_flag
);

    localparam logic [9:0] SECOND_COUNT = 10'(1000 / CALLBACK_PERIOD_MS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_APPLY  = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    localparam int GW = tfda_pkg::GRAMS_W;
    localparam int DW = tfda_pkg::DIST_W;

    logic [2:0]   state_reg;

    // configuration
    logic [31:0]  tps_reg;
    logic [31:0]  stale_reg;
    logic [15:0]  scale_reg;

    // latched item
    logic [2:0]   op_reg;
    logic [GW-1:0] grams_reg;
    logic [31:0]  now_reg;
    logic [15:0]  speed_reg;
    logic         running_reg;
    logic         accepted_reg;
    logic         request_reg;

    // trip state
    logic [31:0]  gram_count_reg;
    logic [GW-1:0] fuel_rem_reg;
    logic [31:0]  meter_count_reg;
    logic [DW-1:0] dist_rem_reg;
    logic [31:0]  ignition_count_reg;
    logic [31:0]  running_count_reg;
    logic [9:0]   prescale_reg;
    logic [31:0]  last_pulse_reg;
    logic [tfda_pkg::RATE_W-1:0] rate_reg;
    logic         dirty_reg;
    logic         queued_reg;
    logic         seen_reg;
    logic         fault_reg;

    // result snapshot
    logic         out_valid_reg;
    logic [31:0]  out_grams_reg;
    logic [31:0]  out_meters_reg;
    logic [31:0]  out_ignition_reg;
    logic [31:0]  out_engine_reg;
    logic [tfda_pkg::RATE_W-1:0] out_rate_reg;
    logic         out_dirty_reg;
    logic         out_request_reg;
    logic         out_fault_reg;

    // shared units
    logic [tfda_pkg::MUL_W-1:0]  mul_a;
    logic [tfda_pkg::MUL_W-1:0]  mul_b;
    logic [tfda_pkg::PROD_W-1:0] mul_product;
    logic                        div_start;
    logic [tfda_pkg::RATE_W-1:0] div_quotient;
    logic                        div_done;

    // fuel path
    logic [GW:0]   fuel_sum;
    logic          fuel_fault;
    logic [31:0]   elapsed;
    logic          rate_stale;
    logic          rate_zero_gap;

    // distance path
    logic [DW:0]   dist_sum;
    logic          dist_fault;
    logic [DW:0]   dist_r;
    logic          dist_carry;
    logic [DW:0]   dist_dec;
    logic [DW-1:0] dist_left;
    logic [9:0]    prescale_inc;
    logic          second_hit;

    logic          in_fire;
    logic          out_load;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    assign mul_a = (op_reg == tfda_pkg::OP_FUEL) ? 32'(grams_reg) : 32'(speed_reg);
    assign mul_b = (op_reg == tfda_pkg::OP_FUEL) ? tps_reg : 32'(scale_reg);

    tfda_mul u_mul
    (
        .clk       (clk),
        .enable    (state_reg == ST_MUL),
        .operand_a (mul_a),
        .operand_b (mul_b),
        .product   (mul_product)
    );

    assign fuel_sum      = {1'b0, fuel_rem_reg} + {1'b0, grams_reg};
    assign fuel_fault    = fuel_sum > tfda_pkg::FUEL_LIMIT_Q16;
    assign elapsed       = now_reg - last_pulse_reg;
    assign rate_stale    = elapsed > stale_reg;
    assign rate_zero_gap = (elapsed == 32'd0);

    assign div_start = (state_reg == ST_APPLY) && (op_reg == tfda_pkg::OP_FUEL)
                       && !fuel_fault && !rate_stale && !rate_zero_gap;

    tfda_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_product[tfda_pkg::DIVD_W+7:8]),
        .divisor  (elapsed),
        .quotient (div_quotient),
        .done     (div_done)
    );

    assign dist_sum   = {1'b0, dist_rem_reg} + (DW+1)'(mul_product[31:0]);
    assign dist_fault = dist_sum > tfda_pkg::DIST_LIMIT_Q24;
    assign dist_r     = dist_fault ? '0 : dist_sum;
    assign dist_carry = dist_r > tfda_pkg::DIST_ONE_Q24;
    assign dist_dec   = dist_r - (DW+1)'(1);
    // remainder after carrying all but the last partial metre lands in (0, 1]
    assign dist_left  = DW'(dist_dec[23:0]) + DW'(1);

    assign prescale_inc = prescale_reg + 10'd1;
    assign second_hit   = (prescale_inc == SECOND_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            tps_reg            <= tfda_pkg::TPS_RESET;
            stale_reg          <= tfda_pkg::STALE_RESET;
            scale_reg          <= tfda_pkg::SCALE_RESET;
            gram_count_reg     <= '0;
            fuel_rem_reg       <= '0;
            meter_count_reg    <= '0;
            dist_rem_reg       <= '0;
            ignition_count_reg <= '0;
            running_count_reg  <= '0;
            prescale_reg       <= '0;
            last_pulse_reg     <= '0;
            rate_reg           <= '0;
            dirty_reg          <= 1'b0;
            queued_reg         <= 1'b0;
            seen_reg           <= 1'b0;
            fault_reg          <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    tfda_pkg::CFG_TICKS_PER_SECOND: tps_reg   <= cfg_data;
                    tfda_pkg::CFG_STALE_TICKS:      stale_reg <= cfg_data;
                    tfda_pkg::CFG_DISTANCE_SCALE:   scale_reg <= cfg_data[15:0];
                    default:                        ;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_APPLY;
                end
                ST_APPLY:
                begin
                    state_reg <= div_start ? ST_DIV : ST_FINISH;
                    unique case (op_reg)
                        tfda_pkg::OP_FUEL:
                        begin
                            queued_reg <= 1'b0;
                            seen_reg   <= 1'b1;
                            if (fuel_fault)
                            begin
                                fault_reg    <= 1'b1;
                                fuel_rem_reg <= fuel_sum[GW] ? '1 : fuel_sum[GW-1:0];
                            end
                            else
                            begin
                                if (fuel_sum[GW:16] != '0)
                                begin
                                    gram_count_reg <= gram_count_reg + 32'(fuel_sum[GW:16]);
                                    dirty_reg      <= 1'b1;
                                end
                                fuel_rem_reg   <= GW'(fuel_sum[15:0]);
                                last_pulse_reg <= now_reg;
                                if (rate_stale)
                                begin
                                    rate_reg <= '0;
                                end
                                else if (rate_zero_gap)
                                begin
                                    rate_reg <= tfda_pkg::RATE_MAX;
                                end
                            end
                        end
                        tfda_pkg::OP_TICK:
                        begin
                            if (dist_fault)
                            begin
                                fault_reg <= 1'b1;
                            end
                            if (dist_carry)
                            begin
                                meter_count_reg <= meter_count_reg
                                                   + 32'(dist_dec[DW:24]);
                                dist_rem_reg    <= dist_left;
                            end
                            else
                            begin
                                dist_rem_reg <= dist_r[DW-1:0];
                            end
                            if (second_hit)
                            begin
                                prescale_reg       <= '0;
                                ignition_count_reg <= ignition_count_reg + 32'd1;
                                if (running_reg)
                                begin
                                    running_count_reg <= running_count_reg + 32'd1;
                                    queued_reg        <= 1'b0;
                                    seen_reg          <= 1'b1;
                                end
                            end
                            else
                            begin
                                prescale_reg <= prescale_inc;
                            end
                            if (dist_carry || second_hit)
                            begin
                                dirty_reg <= 1'b1;
                            end
                        end
                        tfda_pkg::OP_STOP:
                        begin
                            if (seen_reg && !queued_reg && dirty_reg && accepted_reg)
                            begin
                                queued_reg <= 1'b1;
                            end
                        end
                        tfda_pkg::OP_STORE:
                        begin
                            dirty_reg <= 1'b0;
                        end
                        tfda_pkg::OP_CLEAR:
                        begin
                            gram_count_reg     <= '0;
                            fuel_rem_reg       <= '0;
                            meter_count_reg    <= '0;
                            dist_rem_reg       <= '0;
                            ignition_count_reg <= '0;
                            running_count_reg  <= '0;
                            prescale_reg       <= '0;
                            rate_reg           <= '0;
                            last_pulse_reg     <= now_reg;
                            dirty_reg          <= 1'b1;
                            queued_reg         <= 1'b0;
                            seen_reg           <= 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        rate_reg  <= div_quotient;
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // item latch, request flag and result snapshot
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg       <= operation;
            grams_reg    <= fuel_grams_q16;
            now_reg      <= now_ticks;
            speed_reg    <= vehicle_speed_q8;
            running_reg  <= engine_running;
            accepted_reg <= write_accepted;
        end
        if (state_reg == ST_APPLY)
        begin
            request_reg <= (op_reg == tfda_pkg::OP_STOP) && seen_reg && !queued_reg
                           && dirty_reg && accepted_reg;
        end
        if (out_load)
        begin
            out_grams_reg    <= gram_count_reg;
            out_meters_reg   <= meter_count_reg;
            out_ignition_reg <= ignition_count_reg;
            out_engine_reg   <= running_count_reg;
            out_rate_reg     <= rate_reg;
            out_dirty_reg    <= dirty_reg;
            out_request_reg  <= request_reg;
            out_fault_reg    <= fault_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign consumed_grams   = out_grams_reg;
    assign distance_meters  = out_meters_reg;
    assign ignition_seconds = out_ignition_reg;
    assign engine_seconds   = out_engine_reg;
    assign fuel_rate_q8     = out_rate_reg;
    assign dirty_flag       = out_dirty_reg;
    assign write_request    = out_request_reg;
    assign fault_flag       = out_fault_reg;

endmodule
